/* design/koq_pkg.sv */
// Shared types and codes for the keyed order queue.
`timescale 1ns / 1ps

package koq_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 16;
    localparam int ITEM_W   = 3;
    localparam int PRICE_W  = 20;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_ITEM  = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [ITEM_W-1:0]  item;
        logic [PRICE_W-1:0] price;
    } entry_t;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SCAN_RD  = 8'b0000_0010,
        S_SCAN_CMP = 8'b0000_0100,
        S_SHIFT_RD = 8'b0000_1000,
        S_SHIFT_WR = 8'b0001_0000,
        S_DUMP_RD  = 8'b0010_0000,
        S_DUMP_OUT = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

endpackage

/* design/koq_cmd_if.sv */
// Command channel interface: valid/ready with one command beat.
`timescale 1ns / 1ps

interface koq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [koq_pkg::OP_W-1:0]    op;
    logic [koq_pkg::KEY_W-1:0]   order_key;
    logic [koq_pkg::ITEM_W-1:0]  item_code;
    logic [koq_pkg::PRICE_W-1:0] item_price;

    modport source (output valid, op, order_key, item_code, item_price, input ready);
    modport sink (input valid, op, order_key, item_code, item_price, output ready);
endinterface

/* design/koq_rsp_if.sv */
// Response channel interface: valid/ready with one result beat.
`timescale 1ns / 1ps

interface koq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [koq_pkg::STATUS_W-1:0] status;
    logic [koq_pkg::KEY_W-1:0]    found_key;
    logic [koq_pkg::ITEM_W-1:0]   found_item;
    logic [koq_pkg::PRICE_W-1:0]  found_price;
    logic                         last;

    modport source (output valid, status, found_key, found_item, found_price, last,
                    input ready);
    modport sink (input valid, status, found_key, found_item, found_price, last,
                  output ready);
endinterface

/* design/keyed_order_queue_top.sv */
// Keyed order queue: bounded FIFO with key search, update, delete and dump.
// Push and empty results go out through the emit state; unknown opcodes give no result.
// Search, update and remove scan the entries (read, then compare) up to the first match;
// removal then moves the tail down one entry at a time (read, then write). Dump reads
// each entry and returns it as its own result. One command at a time, ready only when idle.
// Reset clears the entry count and handshake state; the entry RAM is not cleared.
`timescale 1ns / 1ps

module keyed_order_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MENU_COUNT  = 5
) (
    input logic       clk,
    input logic       rst_n,
    koq_cmd_if.sink   cmd,
    koq_rsp_if.source rsp
);

    import koq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [OP_W-1:0]    op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [ITEM_W-1:0]  item_reg;
    logic [PRICE_W-1:0] price_reg;

    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    entry_t              pend_entry_reg, pend_entry_next;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    entry_t              rsp_entry_reg;
    logic                rsp_last_reg;

    logic       ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t     ram_wdata, ram_rdata;

    logic             accept;
    logic             can_emit;
    logic             out_load;
    logic             out_from_ram;
    logic [CNT_W-1:0] idx_plus1;
    logic             cmd_item_ok;
    logic             reg_item_ok;
    logic             at_last;

    koq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd.ready   = (state_reg == S_IDLE);
    assign accept      = cmd.valid && cmd.ready;
    assign can_emit    = !rsp_valid_reg || rsp.ready;
    assign idx_plus1   = CNT_W'(idx_reg) + CNT_W'(1);
    assign at_last     = (idx_plus1 >= count_reg);
    assign cmd_item_ok = ({1'b0, cmd.item_code} < (ITEM_W + 1)'(MENU_COUNT));
    assign reg_item_ok = ({1'b0, item_reg} < (ITEM_W + 1)'(MENU_COUNT));

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_entry_next  = pend_entry_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = idx_reg;
        out_load         = 1'b0;
        out_from_ram     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    pend_entry_next = '0;
                    if (cmd.op == OP_PUSH)
                    begin
                        state_next = S_EMIT;
                        if (!cmd_item_ok)
                        begin
                            pend_status_next = ST_BAD_ITEM;
                        end
                        else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            pend_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = IDX_W'(count_reg);
                            ram_wdata.key    = cmd.order_key;
                            ram_wdata.item   = cmd.item_code;
                            ram_wdata.price  = cmd.item_price;
                            count_next       = count_reg + CNT_W'(1);
                            pend_status_next = ST_OK;
                        end
                    end
                    else if (cmd.op > OP_DUMP)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        case (cmd.op) inside
                            OP_POP:                          state_next = S_SHIFT_RD;
                            OP_REMOVE, OP_UPDATE, OP_SEARCH: state_next = S_SCAN_RD;
                            default:                         state_next = S_DUMP_RD;
                        endcase
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (ram_rdata.key == key_reg)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else if (op_reg == OP_UPDATE)
                    begin
                        state_next = S_EMIT;
                        if (!reg_item_ok)
                        begin
                            pend_status_next = ST_BAD_ITEM;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            ram_wdata.item   = item_reg;
                            ram_wdata.price  = price_reg;
                            pend_status_next = ST_OK;
                        end
                    end
                    else
                    begin
                        pend_status_next = ST_OK;
                        pend_entry_next  = ram_rdata;
                        state_next       = S_EMIT;
                    end
                end
                else if (at_last)
                begin
                    pend_status_next = ST_NOT_FOUND;
                    state_next       = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (at_last)
                begin
                    count_next       = count_reg - CNT_W'(1);
                    pend_status_next = ST_OK;
                    state_next       = S_EMIT;
                end
                else
                begin
                    ram_raddr  = IDX_W'(idx_plus1);
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_SHIFT_RD;
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (can_emit)
                begin
                    out_load     = 1'b1;
                    out_from_ram = 1'b1;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_entry_reg  <= pend_entry_next;
        if (accept)
        begin
            op_reg    <= cmd.op;
            key_reg   <= cmd.order_key;
            item_reg  <= cmd.item_code;
            price_reg <= cmd.item_price;
        end
        if (out_load)
        begin
            if (out_from_ram)
            begin
                rsp_status_reg <= ST_OK;
                rsp_entry_reg  <= ram_rdata;
                rsp_last_reg   <= at_last;
            end
            else
            begin
                rsp_status_reg <= pend_status_reg;
                rsp_entry_reg  <= pend_entry_reg;
                rsp_last_reg   <= 1'b1;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.found_key   = rsp_entry_reg.key;
    assign rsp.found_item  = rsp_entry_reg.item;
    assign rsp.found_price = rsp_entry_reg.price;
    assign rsp.last        = rsp_last_reg;

endmodule

/* design/koq_ram.sv */
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps

module koq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/koq_checker.sv */
// Port-level checks for the keyed order queue, bound to the top level.
`timescale 1ns / 1ps

module koq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cmd_valid,
    input logic                         cmd_ready,
    input logic [koq_pkg::OP_W-1:0]     cmd_op,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [koq_pkg::STATUS_W-1:0] rsp_status,
    input logic [koq_pkg::KEY_W-1:0]    rsp_found_key,
    input logic [koq_pkg::ITEM_W-1:0]   rsp_found_item,
    input logic [koq_pkg::PRICE_W-1:0]  rsp_found_price,
    input logic                         rsp_last
);

    import koq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_op <= OP_DUMP) |=> !cmd_ready)
        else $error("ready high right after a valid command");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status <= ST_BAD_ITEM))
        else $error("status code out of range");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            rsp_last && (rsp_found_key == '0) && (rsp_found_item == '0)
            && (rsp_found_price == '0))
        else $error("error result with entry fields or without last");

endmodule

bind keyed_order_queue_top koq_checker u_koq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_op          (cmd.op),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_key   (rsp.found_key),
    .rsp_found_item  (rsp.found_item),
    .rsp_found_price (rsp.found_price),
    .rsp_last        (rsp.last)
);

/* tb/tb.sv */
// Testbench for the keyed order queue: directed, fill-to-full and random commands.
`timescale 1ns / 1ps

module tb;

    import koq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int MENU_CNT    = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [ITEM_W-1:0]   item;
        logic [PRICE_W-1:0]  price;
        logic                last;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    koq_cmd_if cmd_bus ();
    koq_rsp_if rsp_bus ();

    keyed_order_queue_top #(
        .QUEUE_DEPTH(DEPTH),
        .MENU_COUNT (MENU_CNT)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_bus),
        .rsp  (rsp_bus)
    );

    entry_t           book[$];
    reply_t           replies_due[$];
    logic [KEY_W-1:0] key_pool[8];
    int unsigned      send_gap_pct;
    int unsigned      recv_gap_pct;
    int unsigned      fail_count;
    int unsigned      cycle_count;
    bit               hold_rsp;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void note_failure(string msg);
        if (fail_count < 10)
            $display("%0t: %s", $realtime, msg);
        fail_count++;
    endfunction

    function automatic void add_reply(logic [STATUS_W-1:0] status, entry_t e, logic last);
        reply_t r;
        r.status = status;
        r.key    = e.key;
        r.item   = e.item;
        r.price  = e.price;
        r.last   = last;
        replies_due.push_back(r);
    endfunction

    // Order book model: updates the entries and queues the replies one command causes.
    function automatic void apply_order_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                            logic [ITEM_W-1:0] item,
                                            logic [PRICE_W-1:0] price);
        entry_t none;
        entry_t e;
        int     pos;
        bit     item_ok;
        none    = '0;
        item_ok = (item < MENU_CNT);
        pos     = -1;
        foreach (book[i])
        begin
            if (pos < 0 && book[i].key == key)
                pos = i;
        end
        if (op > OP_DUMP)
            return;
        if (op == OP_PUSH)
        begin
            if (!item_ok)
                add_reply(ST_BAD_ITEM, none, 1'b1);
            else if (book.size() >= DEPTH)
                add_reply(ST_FULL, none, 1'b1);
            else
            begin
                e.key   = key;
                e.item  = item;
                e.price = price;
                book.push_back(e);
                add_reply(ST_OK, none, 1'b1);
            end
            return;
        end
        if (book.size() == 0)
        begin
            add_reply(ST_EMPTY, none, 1'b1);
            return;
        end
        case (op)
            OP_POP:
            begin
                void'(book.pop_front());
                add_reply(ST_OK, none, 1'b1);
            end
            OP_REMOVE:
            begin
                if (pos < 0)
                    add_reply(ST_NOT_FOUND, none, 1'b1);
                else
                begin
                    book.delete(pos);
                    add_reply(ST_OK, none, 1'b1);
                end
            end
            OP_UPDATE:
            begin
                if (pos < 0)
                    add_reply(ST_NOT_FOUND, none, 1'b1);
                else if (!item_ok)
                    add_reply(ST_BAD_ITEM, none, 1'b1);
                else
                begin
                    book[pos].item  = item;
                    book[pos].price = price;
                    add_reply(ST_OK, none, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                if (pos < 0)
                    add_reply(ST_NOT_FOUND, none, 1'b1);
                else
                    add_reply(ST_OK, book[pos], 1'b1);
            end
            default:
            begin
                foreach (book[i])
                    add_reply(ST_OK, book[i], i == book.size() - 1);
            end
        endcase
    endfunction

    // Drives one command beat and updates the model when it is taken.
    task automatic issue_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [ITEM_W-1:0] item, logic [PRICE_W-1:0] price);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.op         <= op;
        cmd_bus.order_key  <= key;
        cmd_bus.item_code  <= item;
        cmd_bus.item_price <= price;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        apply_order_cmd(op, key, item, price);
    endtask

    always @(negedge clk)
        rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= recv_gap_pct);

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = {rsp_bus.status, rsp_bus.found_key, rsp_bus.found_item,
                   rsp_bus.found_price, rsp_bus.last};
            if (replies_due.size() == 0)
                note_failure($sformatf("unexpected result beat: status %0d key %h",
                                       got.status, got.key));
            else
            begin
                want = replies_due.pop_front();
                if (got !== want)
                    note_failure($sformatf({"result mismatch: exp st %0d key %h item %0d ",
                        "price %h last %b, got st %0d key %h item %0d price %h last %b"},
                        want.status, want.key, want.item, want.price, want.last,
                        got.status, got.key, got.item, got.price, got.last));
            end
        end
    end

    task automatic test_directed();
        issue_cmd(OP_POP, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_REMOVE, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_UPDATE, 16'hFFFF, 3'd1, 20'hFFFFF);
        issue_cmd(OP_SEARCH, 16'hFFFF, 3'd0, 20'h00000);
        issue_cmd(OP_DUMP, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_PUSH, 16'hFFFF, 3'd5, 20'hFFFFF);
        issue_cmd(OP_PUSH, 16'h0001, 3'd7, 20'h00001);
        issue_cmd(OP_PUSH, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_PUSH, 16'hFFFF, 3'd4, 20'hFFFFF);
        issue_cmd(OP_PUSH, 16'h1234, 3'd2, 20'h5A5A5);
        issue_cmd(OP_PUSH, 16'h0000, 3'd1, 20'hA5A5A);
        issue_cmd(OP_SEARCH, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_SEARCH, 16'hBEEF, 3'd0, 20'h00000);
        issue_cmd(OP_UPDATE, 16'hFFFF, 3'd6, 20'h12345);
        issue_cmd(OP_UPDATE, 16'h7777, 3'd7, 20'h12345);
        issue_cmd(OP_UPDATE, 16'h1234, 3'd3, 20'hFFFFF);
        issue_cmd(OP_REMOVE, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_REMOVE, 16'h4321, 3'd0, 20'h00000);
        issue_cmd(OP_DUMP, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(3'd6, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(3'd7, 16'hFFFF, 3'd7, 20'hFFFFF);
        issue_cmd(OP_POP, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_DUMP, 16'h0000, 3'd0, 20'h00000);
    endtask

    // Receiver stalls at first; two pushes too many fill the queue and are refused.
    task automatic test_fill_full();
        int               n;
        logic [KEY_W-1:0] rear_key;
        logic [KEY_W-1:0] front_key;
        rear_key = '0;
        fork
            begin
                hold_rsp = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
        join_none
        n = DEPTH - book.size() + 2;
        repeat (n)
        begin
            rear_key = KEY_W'($urandom);
            issue_cmd(OP_PUSH, rear_key, ITEM_W'($urandom_range(MENU_CNT - 1)),
                      PRICE_W'($urandom));
        end
        front_key = book[0].key;
        issue_cmd(OP_DUMP, 16'h0000, 3'd0, 20'h00000);
        issue_cmd(OP_SEARCH, book[DEPTH - 1].key, 3'd0, 20'h00000);
        issue_cmd(OP_REMOVE, book[DEPTH - 1].key, 3'd0, 20'h00000);
        issue_cmd(OP_REMOVE, front_key, 3'd0, 20'h00000);
        issue_cmd(OP_DUMP, 16'h0000, 3'd0, 20'h00000);
    endtask

    task automatic test_random(int unsigned n);
        int unsigned       done;
        int unsigned       pick;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [ITEM_W-1:0] item;
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                op = OP_PUSH;
            else if (pick < 48)
                op = OP_POP;
            else if (pick < 62)
                op = OP_REMOVE;
            else if (pick < 76)
                op = OP_UPDATE;
            else if (pick < 90)
                op = OP_SEARCH;
            else if (pick < 96)
                op = OP_DUMP;
            else
                op = OP_W'($urandom_range(7, 6));
            if (op != OP_PUSH && book.size() != 0 && $urandom_range(99) < 65)
                key = book[$urandom_range(book.size() - 1)].key;
            else if ($urandom_range(99) < 50)
                key = key_pool[$urandom_range(7)];
            else
                key = KEY_W'($urandom);
            if ($urandom_range(99) < 85)
                item = ITEM_W'($urandom_range(MENU_CNT - 1));
            else
                item = ITEM_W'($urandom_range(7, MENU_CNT));
            issue_cmd(op, key, item, PRICE_W'($urandom));
            if (op <= OP_DUMP)
                done++;
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        hold_rsp           = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.op         = '0;
        cmd_bus.order_key  = '0;
        cmd_bus.item_code  = '0;
        cmd_bus.item_price = '0;
        key_pool[0]        = 16'h0000;
        key_pool[1]        = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = KEY_W'($urandom);
        send_gap_pct = 14;
        recv_gap_pct = 64;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fill_full();
        test_random(120);
        send_gap_pct = 64;
        recv_gap_pct = 14;
        test_random(120);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random(120);

        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* keyed_order_queue_top.f */
design/koq_pkg.sv
design/koq_cmd_if.sv
design/koq_rsp_if.sv
design/koq_ram.sv
design/keyed_order_queue_top.sv
design/koq_checker.sv
tb/tb.sv
